// ----- sv/jsu_pkg.sv -----
`default_nettype none
package jsu_pkg;

    // One input beat: a text byte with its framing flags.
    typedef struct packed {
        logic       start_of_string;
        logic [7:0] in_byte;
        logic       input_ended;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last_of_run;
    } out_t;

    localparam int MAX_RES = 3;
    localparam int RUN_CW  = $clog2(MAX_RES + 1);
    localparam int RES_IW  = $clog2(MAX_RES);

    // All results caused by one input beat.
    typedef struct packed {
        logic [RUN_CW-1:0]       n;
        out_t [MAX_RES-1:0]      res;
    } run_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX
    } phase_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_EXPECTED = 3'd0;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd1;
    localparam logic [2:0] ERR_BAD_U    = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd4;
    localparam logic [2:0] ERR_UNTERM   = 3'd5;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    function automatic out_t mk_result(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [2:0] code);
        out_t r;
        r.result_kind = kind;
        r.out_byte    = b;
        r.error_code  = code;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/jsu_front.sv -----
`default_nettype none
module jsu_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire jsu_pkg::in_t  s_data,
    input  wire jsu_pkg::q_status_t q_status,
    output logic               push,
    output jsu_pkg::run_t      push_run
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LOW6  = 8'h3F;
    localparam logic [15:0] CP_TWO   = 16'h0080;
    localparam logic [15:0] CP_THREE = 16'h0800;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic        accept;
    logic [7:0]  c;
    logic        hex_ok;
    logic [3:0]  hex_nib;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic [15:0] acc_shift;
    run_t        run;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.in_byte;

    always_comb begin
        hex_ok  = 1'b1;
        hex_nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            hex_nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            hex_nib = 4'(c - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = c;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = c;
            8'h62: esc_byte = 8'h08;
            8'h66: esc_byte = 8'h0C;
            8'h6E: esc_byte = 8'h0A;
            8'h72: esc_byte = 8'h0D;
            8'h74: esc_byte = 8'h09;
            default: esc_ok = 1'b0;
        endcase
    end

    assign acc_shift = {acc_reg[11:0], hex_nib};

    // Next state
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            if (s_data.start_of_string) begin
                acc_next   = '0;
                cnt_next   = '0;
                phase_next = (s_data.input_ended || c != CH_QUOTE) ? PH_IDLE : PH_BODY;
            end else begin
                case (phase_reg)
                    PH_IDLE: phase_next = PH_IDLE;
                    PH_BODY: begin
                        if (s_data.input_ended || c == CH_QUOTE) begin
                            phase_next = PH_IDLE;
                        end else if (c == CH_BSLASH) begin
                            phase_next = PH_ESC;
                        end
                    end
                    PH_ESC: begin
                        if (s_data.input_ended) begin
                            phase_next = PH_IDLE;
                        end else if (c == CH_U) begin
                            phase_next = PH_HEX;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end else if (esc_ok) begin
                            phase_next = PH_BODY;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_HEX: begin
                        if (s_data.input_ended || !hex_ok) begin
                            phase_next = PH_IDLE;
                        end else begin
                            acc_next = acc_shift;
                            if (cnt_reg != 2'd3) begin
                                cnt_next = cnt_reg + 2'd1;
                            end else begin
                                cnt_next   = '0;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Results of the current beat
    always_comb begin
        run.n   = '0;
        run.res = '0;
        if (s_data.start_of_string) begin
            if (s_data.input_ended || c != CH_QUOTE) begin
                run.n      = RUN_CW'(1);
                run.res[0] = mk_result(KIND_ERROR, 8'h00, ERR_EXPECTED);
            end
        end else begin
            case (phase_reg)
                PH_IDLE: run.n = '0;
                PH_BODY: begin
                    run.n = RUN_CW'(1);
                    if (s_data.input_ended) begin
                        run.res[0] = mk_result(KIND_ERROR, 8'h00, ERR_UNTERM);
                    end else if (c == CH_QUOTE) begin
                        run.res[0] = mk_result(KIND_CLOSE, 8'h00, ERR_EXPECTED);
                    end else if (c == CH_BSLASH) begin
                        run.n = '0;
                    end else begin
                        run.res[0] = mk_result(KIND_DATA, c, ERR_EXPECTED);
                    end
                end
                PH_ESC: begin
                    run.n = RUN_CW'(1);
                    if (s_data.input_ended) begin
                        run.res[0] = mk_result(KIND_ERROR, 8'h00, ERR_BAD_ESC);
                    end else if (c == CH_U) begin
                        run.n = '0;
                    end else if (esc_ok) begin
                        run.res[0] = mk_result(KIND_DATA, esc_byte, ERR_EXPECTED);
                    end else begin
                        run.res[0] = mk_result(KIND_ERROR, 8'h00, ERR_UNKNOWN);
                    end
                end
                PH_HEX: begin
                    if (s_data.input_ended) begin
                        run.n      = RUN_CW'(1);
                        run.res[0] = mk_result(KIND_ERROR, 8'h00, ERR_BAD_U);
                    end else if (!hex_ok) begin
                        run.n      = RUN_CW'(1);
                        run.res[0] = mk_result(KIND_ERROR, 8'h00, ERR_BAD_HEX);
                    end else if (cnt_reg == 2'd3) begin
                        if (acc_shift < CP_TWO) begin
                            run.n      = RUN_CW'(1);
                            run.res[0] = mk_result(KIND_DATA, acc_shift[7:0], ERR_EXPECTED);
                        end else if (acc_shift < CP_THREE) begin
                            run.n      = RUN_CW'(2);
                            run.res[0] = mk_result(KIND_DATA,
                                UTF8_LEAD2 | {3'b000, acc_shift[10:6]}, ERR_EXPECTED);
                            run.res[1] = mk_result(KIND_DATA,
                                UTF8_CONT | (acc_shift[7:0] & UTF8_LOW6), ERR_EXPECTED);
                        end else begin
                            run.n      = RUN_CW'(3);
                            run.res[0] = mk_result(KIND_DATA,
                                UTF8_LEAD3 | {4'h0, acc_shift[15:12]}, ERR_EXPECTED);
                            run.res[1] = mk_result(KIND_DATA,
                                UTF8_CONT | (acc_shift[13:6] & UTF8_LOW6), ERR_EXPECTED);
                            run.res[2] = mk_result(KIND_DATA,
                                UTF8_CONT | (acc_shift[7:0] & UTF8_LOW6), ERR_EXPECTED);
                        end
                    end
                end
                default: run.n = '0;
            endcase
        end
        // flag the final result of the run
        case (run.n)
            RUN_CW'(1): run.res[0].last_of_run = 1'b1;
            RUN_CW'(2): run.res[1].last_of_run = 1'b1;
            RUN_CW'(3): run.res[2].last_of_run = 1'b1;
            default: ;
        endcase
    end

    assign push     = accept && (run.n != '0);
    assign push_run = run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/jsu_queue.sv -----
`default_nettype none
module jsu_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire jsu_pkg::run_t push_run,
    input  wire logic          pop,
    output jsu_pkg::run_t      pop_run,
    output jsu_pkg::q_status_t q_status
);
    import jsu_pkg::*;

    run_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_run        = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (QAW+1)'(1);
            2'b01:   count_next = count_reg - (QAW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule
`default_nettype wire

// ----- sv/jsu_back.sv -----
`default_nettype none
module jsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire jsu_pkg::run_t pop_run,
    input  wire jsu_pkg::q_status_t q_status,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output jsu_pkg::out_t      m_data
);
    import jsu_pkg::*;

    run_t              cur_reg;
    logic [RES_IW-1:0] idx_reg;
    logic              valid_reg;
    logic              last_beat;

    assign last_beat = (RUN_CW'(idx_reg) == RUN_CW'(cur_reg.n - RUN_CW'(1)));
    assign pop       = !q_status.empty && (!valid_reg || (m_ready && last_beat));
    assign m_valid   = valid_reg;
    assign m_data    = cur_reg.res[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            if (last_beat) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + RES_IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= pop_run;
        end
    end

endmodule
`default_nettype wire

// ----- sv/json_string_unescape_unit.sv -----
// JSON string unescape unit.
// s_ channel: one text byte per beat (s_valid/s_ready, payload s_data). Flag the
// opening quote with start_of_string; send a beat with input_ended to close out
// the text. m_ channel: decoded results (m_valid/m_ready, payload m_data), one
// per beat: data bytes, a close marker, or a single error code. last_of_run
// marks the final result caused by one input beat; a \u escape gives up to
// three UTF-8 bytes for its last hex digit, beats that give nothing show none.
// Throughput: one input beat per cycle while each beat yields at most one
// result and the receiver keeps m_ready high; a beat yielding k results takes k
// output beats, bounded by the single-result-per-cycle output port.
// Each run is written to the run queue, then loaded into the output register.
// A four-deep run queue separates the decoder from the output serializer, so
// input keeps flowing while the receiver stalls until the queue fills; then
// s_ready drops and no data is lost.
// Reset (aresetn low, synchronous) returns the decoder to idle, empties the
// queue and drops any result in flight; no clearing pass is needed.
`default_nettype none
module json_string_unescape_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire jsu_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output jsu_pkg::out_t      m_data
);
    import jsu_pkg::*;

    logic      push, pop;
    run_t      push_run, pop_run;
    q_status_t q_status;

    // decode and classify each beat into a run of results
    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .push_run (push_run)
    );

    // hold runs between decoder and serializer
    jsu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .pop_run  (pop_run),
        .q_status (q_status)
    );

    // drain each run one result beat at a time
    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_run  (pop_run),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

// ----- sv/jsu_checker.sv -----
`default_nettype none
module jsu_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire jsu_pkg::out_t m_data
);
    import jsu_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // an error always ends its run
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == KIND_ERROR |-> m_data.last_of_run)
        else $error("error result not last of run");

    // non-data results carry no byte, non-error results carry no code
    a_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.result_kind == KIND_DATA || m_data.out_byte == 8'h00) &&
                    (m_data.result_kind == KIND_ERROR || m_data.error_code == ERR_EXPECTED))
        else $error("unused result field not zero");

    // input stalls only while output holds a result
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with output empty");

    // drop results on reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (.*);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import jsu_pkg::*;

    // Characters that steer the decoder.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // The eight one-byte escape letters.
    localparam logic [7:0] ESC_LETTER [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62,
                                              8'h66, 8'h6E, 8'h72, 8'h74};

    localparam int RANDOM_ITEMS = 260;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // One row of the directed table. When typed is set, the row carries its
    // own expected result; otherwise the decoder model supplies it.
    typedef struct packed {
        logic       start;
        logic [7:0] ch;
        logic       ended;
        logic       typed;
        logic [1:0] kind;
        logic [7:0] b;
        logic [2:0] code;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [26] = '{
        // idle without start: no result
        '{1'b0, 8'h78,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        // start on a non-quote byte, then start on end of input
        '{1'b1, 8'hFF,     1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_EXPECTED},
        '{1'b1, CH_QUOTE,  1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_EXPECTED},
        // open, then the extreme plain bytes
        '{1'b1, CH_QUOTE,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h00,     1'b0, 1'b1, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'hFF,     1'b0, 1'b1, KIND_DATA,  8'hFF, ERR_EXPECTED},
        // \t
        '{1'b0, CH_BSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h74,     1'b0, 1'b1, KIND_DATA,  8'h09, ERR_EXPECTED},
        // \uFfaB, mixed case, three UTF-8 bytes
        '{1'b0, CH_BSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, CH_U,      1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h46,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h66,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h61,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h42,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        // close
        '{1'b0, CH_QUOTE,  1'b0, 1'b1, KIND_CLOSE, 8'h00, ERR_EXPECTED},
        // unknown escape letter
        '{1'b1, CH_QUOTE,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, CH_BSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h71,     1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_UNKNOWN},
        // bad hex digit right after \u
        '{1'b1, CH_QUOTE,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, CH_BSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, CH_U,      1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'h67,     1'b0, 1'b1, KIND_ERROR, 8'h00, ERR_BAD_HEX},
        // restart in the middle of an escape, then run out of text
        '{1'b1, CH_QUOTE,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, CH_BSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b1, CH_QUOTE,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_EXPECTED},
        '{1'b0, 8'hA5,     1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_UNTERM}
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    json_string_unescape_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Decoder model state.
    phase_t      dec_phase = PH_IDLE;
    logic [15:0] hex_acc   = '0;
    logic [1:0]  hex_count = '0;
    out_t        decoded_run [$];
    bit          beat_ignored;

    // Results still owed by the unit, oldest first.
    out_t        expected_results [$];

    int          errors      = 0;
    int          items_done  = 0;
    int          cycles      = 0;
    bit          sender_steady = 1'b0;
    int          ready_left  = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Bail out if the unit hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    function automatic void emit(input logic [1:0] kind, input logic [7:0] b,
                                 input logic [2:0] code);
        out_t r;
        r.result_kind = kind;
        r.out_byte    = b;
        r.error_code  = code;
        r.last_of_run = 1'b0;
        decoded_run = {decoded_run, r};
    endfunction

    function automatic void fault(input logic [2:0] code);
        dec_phase = PH_IDLE;
        emit(KIND_ERROR, 8'h00, code);
    endfunction

    // Advance the decoder model by one beat; leave its results in decoded_run.
    function automatic void decode_beat(input in_t beat);
        logic [7:0] c;
        logic [3:0] nib;
        bit         is_hex;
        c = beat.in_byte;
        decoded_run.delete();
        beat_ignored = 1'b0;
        if (beat.start_of_string) begin
            // A start drops whatever string was in progress.
            hex_acc   = '0;
            hex_count = '0;
            if (beat.input_ended || c != CH_QUOTE) begin
                fault(ERR_EXPECTED);
            end else begin
                dec_phase = PH_BODY;
            end
            return;
        end
        case (dec_phase)
            PH_IDLE: begin
                beat_ignored = 1'b1;
            end
            PH_BODY: begin
                if (beat.input_ended) begin
                    fault(ERR_UNTERM);
                end else if (c == CH_QUOTE) begin
                    dec_phase = PH_IDLE;
                    emit(KIND_CLOSE, 8'h00, ERR_EXPECTED);
                end else if (c == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    emit(KIND_DATA, c, ERR_EXPECTED);
                end
            end
            PH_ESC: begin
                if (beat.input_ended) begin
                    fault(ERR_BAD_ESC);
                end else begin
                    dec_phase = PH_BODY;
                    case (c)
                        8'h22, 8'h5C, 8'h2F: emit(KIND_DATA, c, ERR_EXPECTED);
                        8'h62: emit(KIND_DATA, 8'h08, ERR_EXPECTED);
                        8'h66: emit(KIND_DATA, 8'h0C, ERR_EXPECTED);
                        8'h6E: emit(KIND_DATA, 8'h0A, ERR_EXPECTED);
                        8'h72: emit(KIND_DATA, 8'h0D, ERR_EXPECTED);
                        8'h74: emit(KIND_DATA, 8'h09, ERR_EXPECTED);
                        CH_U: begin
                            dec_phase = PH_HEX;
                            hex_acc   = '0;
                            hex_count = '0;
                        end
                        default: fault(ERR_UNKNOWN);
                    endcase
                end
            end
            PH_HEX: begin
                is_hex = 1'b1;
                nib    = '0;
                if (c >= 8'h30 && c <= 8'h39) begin
                    nib = 4'(c - 8'h30);
                end else if (c >= 8'h61 && c <= 8'h66) begin
                    nib = 4'(c - 8'h57);
                end else if (c >= 8'h41 && c <= 8'h46) begin
                    nib = 4'(c - 8'h37);
                end else begin
                    is_hex = 1'b0;
                end
                if (beat.input_ended) begin
                    fault(ERR_BAD_U);
                end else if (!is_hex) begin
                    fault(ERR_BAD_HEX);
                end else begin
                    hex_acc = {hex_acc[11:0], nib};
                    if (hex_count != 2'd3) begin
                        hex_count = hex_count + 2'd1;
                    end else begin
                        // Fourth digit: emit the code point as UTF-8.
                        hex_count = '0;
                        dec_phase = PH_BODY;
                        if (hex_acc < 16'h0080) begin
                            emit(KIND_DATA, hex_acc[7:0], ERR_EXPECTED);
                        end else if (hex_acc < 16'h0800) begin
                            emit(KIND_DATA, {3'b110, hex_acc[10:6]}, ERR_EXPECTED);
                            emit(KIND_DATA, {2'b10, hex_acc[5:0]}, ERR_EXPECTED);
                        end else begin
                            emit(KIND_DATA, {4'b1110, hex_acc[15:12]}, ERR_EXPECTED);
                            emit(KIND_DATA, {2'b10, hex_acc[11:6]}, ERR_EXPECTED);
                            emit(KIND_DATA, {2'b10, hex_acc[5:0]}, ERR_EXPECTED);
                        end
                    end
                end
            end
            default: begin
                dec_phase = PH_IDLE;
            end
        endcase
    endfunction

    // Idle cycles ahead of a beat: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // Present one beat, hold it until accepted, then book its results.
    task automatic feed(input in_t beat, input bit typed, input out_t want);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        decode_beat(beat);
        if (typed) begin
            decoded_run.delete();
            decoded_run = {decoded_run, want};
        end
        if (decoded_run.size() != 0) begin
            decoded_run[decoded_run.size() - 1].last_of_run = 1'b1;
        end
        foreach (decoded_run[i]) begin
            expected_results = {expected_results, decoded_run[i]};
        end
        if (!beat_ignored) begin
            items_done++;
        end
    endtask

    task automatic send_beat(input logic start, input logic [7:0] ch, input logic ended);
        in_t beat;
        beat.start_of_string = start;
        beat.in_byte         = ch;
        beat.input_ended     = ended;
        feed(beat, 1'b0, '0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        // Either case is legal; pick one at random.
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // Send the leading count hex digits of a code point.
    task automatic send_hex(input logic [15:0] cp, input int count);
        for (int i = 0; i < count; i++) begin
            send_beat(1'b0, hex_char(cp[15 - 4 * i -: 4]), 1'b0);
        end
    endtask

    function automatic logic [15:0] random_code_point();
        logic [15:0] edges [6];
        edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
        case ($urandom_range(0, 7))
            0:       return edges[$urandom_range(0, 5)];
            1, 2:    return 16'($urandom_range(16'h0000, 16'h007F));
            3, 4:    return 16'($urandom_range(16'h0080, 16'h07FF));
            default: return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    // One well-formed piece of string body: a plain byte or an escape.
    task automatic send_element();
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            send_beat(1'b0, c, 1'b0);
        end else if (r < 8) begin
            send_beat(1'b0, CH_BSLASH, 1'b0);
            send_beat(1'b0, ESC_LETTER[$urandom_range(0, 7)], 1'b0);
        end else begin
            send_beat(1'b0, CH_BSLASH, 1'b0);
            send_beat(1'b0, CH_U, 1'b0);
            send_hex(random_code_point(), 4);
        end
    endtask

    task automatic send_body();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
        repeat (n) send_element();
    endtask

    // Open a string, send some body, then break it in one of several ways.
    task automatic send_broken_string();
        logic [7:0] c;
        send_beat(1'b1, CH_QUOTE, 1'b0);
        send_body();
        case ($urandom_range(0, 7))
            0: begin
                send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                send_beat(1'b0, CH_BSLASH, 1'b0);
                send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end
            2: begin
                send_beat(1'b0, CH_BSLASH, 1'b0);
                send_beat(1'b0, CH_U, 1'b0);
                send_hex(random_code_point(), $urandom_range(0, 3));
                send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end
            3: begin
                send_beat(1'b0, CH_BSLASH, 1'b0);
                do c = 8'($urandom_range(0, 255));
                while (c inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72,
                                 8'h74, CH_U});
                send_beat(1'b0, c, 1'b0);
            end
            4: begin
                send_beat(1'b0, CH_BSLASH, 1'b0);
                send_beat(1'b0, CH_U, 1'b0);
                send_hex(random_code_point(), $urandom_range(0, 3));
                do c = 8'($urandom_range(0, 255));
                while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                       (c >= 8'h41 && c <= 8'h46));
                send_beat(1'b0, c, 1'b0);
            end
            5: begin
                // Restart inside an escape or a \u, then finish cleanly.
                send_beat(1'b0, CH_BSLASH, 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_beat(1'b0, CH_U, 1'b0);
                    send_hex(random_code_point(), $urandom_range(0, 3));
                end
                send_beat(1'b1, CH_QUOTE, 1'b0);
                send_body();
                send_beat(1'b0, CH_QUOTE, 1'b0);
            end
            6: begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
                send_beat(1'b1, c, 1'b0);
            end
            default: begin
                send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    // Receiver: hold m_ready in runs, mostly short stalls, a few long ones,
    // and now and then a long stretch with no stall at all.
    always @(posedge aclk) begin
        int r;
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(40, 160);
            end else if (r < 10) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 6);
            end else if (r < 18) begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(8, 30);
            end
        end
    end

    // Compare every accepted result beat with the oldest one owed.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: %h", m_data));
            end else begin
                want = expected_results.pop_front();
                if (m_data.result_kind != want.result_kind) begin
                    report_mismatch($sformatf("result_kind got %0d expected %0d",
                                              m_data.result_kind, want.result_kind));
                end
                if (m_data.out_byte != want.out_byte) begin
                    report_mismatch($sformatf("out_byte got %h expected %h",
                                              m_data.out_byte, want.out_byte));
                end
                if (m_data.error_code != want.error_code) begin
                    report_mismatch($sformatf("error_code got %0d expected %0d",
                                              m_data.error_code, want.error_code));
                end
                if (m_data.last_of_run != want.last_of_run) begin
                    report_mismatch($sformatf("last_of_run got %0b expected %0b",
                                              m_data.last_of_run, want.last_of_run));
                end
            end
        end
    end

    initial begin : stimulus
        in_t  beat;
        out_t want;
        int   pick;

        // Hold reset, then release it once.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table.
        foreach (DIRECTED_ROWS[i]) begin
            beat.start_of_string = DIRECTED_ROWS[i].start;
            beat.in_byte         = DIRECTED_ROWS[i].ch;
            beat.input_ended     = DIRECTED_ROWS[i].ended;
            want.result_kind     = DIRECTED_ROWS[i].kind;
            want.out_byte        = DIRECTED_ROWS[i].b;
            want.error_code      = DIRECTED_ROWS[i].code;
            want.last_of_run     = 1'b1;
            feed(beat, DIRECTED_ROWS[i].typed, want);
        end

        // Random part: mostly well-formed strings, the rest broken or noise.
        while (items_done < RANDOM_ITEMS) begin
            sender_steady = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_beat(1'b1, CH_QUOTE, 1'b0);
                send_body();
                send_beat(1'b0, CH_QUOTE, 1'b0);
            end else if (pick < 9) begin
                send_broken_string();
            end else begin
                // Stray beats while idle: the unit should drop them.
                repeat ($urandom_range(1, 4)) begin
                    send_beat(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end
        sender_steady = 1'b0;
        s_valid <= 1'b0;

        // Drain whatever is still owed, then give stray beats time to show.
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
